// File: rtl/vls_pkg.sv
// Shared types, codes and helper functions for the value list store.
package vls_pkg;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_SUM    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic       load;
    logic       push;
    logic       dec;
    logic       start_down;
    logic       start_up;
    logic       start_shift;
    logic       issue;
    logic       up;
    logic       shift_wr;
    logic       res_we;
    logic [1:0] res_status;
    logic       res_pos;
    logic       res_sum;
    logic       post;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       empty;
    logic       full;
    logic       iss_done;
    logic       rd_vld;
    logic       match;
    logic       rd_at_top;
    logic       rd_at_bottom;
    logic       s1_vld;
    logic       s1_last;
    logic       out_free;
  } dp_stat_t;

  // 16 = 1 mod 5, so the nibble sum keeps the residue; then fold and trim.
  function automatic logic [2:0] mod5(input logic [31:0] v);
    logic [6:0] s;
    logic [4:0] t;
    s = 7'd0;
    for (int i = 0; i < 8; i++) begin
      s = s + 7'(v[4*i +: 4]);
    end
    t = 5'(s[6:4]) + 5'(s[3:0]);
    if (t >= 5'd20) begin
      t = t - 5'd20;
    end else if (t >= 5'd10) begin
      t = t - 5'd10;
    end
    if (t >= 5'd5) begin
      t = t - 5'd5;
    end
    return t[2:0];
  endfunction

  // Positive and last decimal digit 7: odd and 2 mod 5.
  function automatic logic ends_in_seven(input logic [31:0] v);
    return !v[31] && v[0] && (mod5(v) == 3'd2);
  endfunction

endpackage

// File: rtl/value_list_store_unit.sv
// Top level of the value list store: ordered list with push, delete, search and sum.
//
// Input channel: in_valid/in_stall with command and value; a beat is taken when
// in_valid is high and in_stall is low. One beat is worked on at a time; in_stall
// is high from the accepting edge until the result is placed in the output register.
// Output channel: out_valid/out_stall with status, position, total and entry_count,
// exactly one result beat per input beat, in order.
// Steps from accept to out_valid, with n entries stored:
//   push, or any command on an empty list: execute state, then post.
//   search: scan from the head to a match or slot 0 (one memory read per cycle).
//   sum: scan of all n entries through the sum pipeline, one read per cycle.
//   delete: scan to the match, then one entry moved toward the tail per cycle,
//   longest when the oldest entry matches; the entry RAM has a single read port.
// A finished result waits in the output register while out_stall is high; the next
// beat may be accepted meanwhile, and its result is held internally until the
// register frees up.
// Reset (rst, synchronous) empties the list and drops any pending result; the
// memory contents are not cleared, as only slots below the fill count are read.
module value_list_store_unit #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [6:0]         position,
  output logic [37:0]        total,
  output logic [6:0]         entry_count
);
  import vls_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  vls_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  vls_dp #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .command    (command),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .position   (position),
    .total      (total),
    .entry_count(entry_count)
  );

endmodule

// File: rtl/vls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/vls_dp.sv
// Datapath: entry memory, fill count, scan address, sum pipeline and result registers.
module vls_dp #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  vls_pkg::dp_cmd_t  cmd,
  output vls_pkg::dp_stat_t stat,
  input  logic [1:0]        command,
  input  logic signed [31:0] value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [6:0]        position,
  output logic [37:0]       total,
  output logic [6:0]        entry_count
);
  import vls_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [1:0]    cmd_r;
  logic [31:0]   val_r;
  logic [CW-1:0] fill;
  logic [AW-1:0] top_addr;
  logic [AW-1:0] iss_addr;
  logic          iss_done;
  logic [AW-1:0] rd_addr;
  logic          rd_vld;
  logic [31:0]   rd_data;
  logic          s1_vld;
  logic [31:0]   s1_add;
  logic          s1_last;
  logic [37:0]   acc;
  logic [37:0]   acc_sum;
  logic [1:0]    res_status;
  logic [6:0]    res_pos;
  logic [37:0]   res_total;
  logic [CW-1:0] pos_calc;
  logic [CW+6:0] pos_ext;
  logic [CW+6:0] fill_ext;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;

  assign top_addr = AW'(fill - CW'(1));
  assign acc_sum  = acc + {6'd0, s1_add};
  assign pos_calc = fill - CW'(rd_addr);
  assign pos_ext  = {7'd0, pos_calc};
  assign fill_ext = {7'd0, fill};

  // Push writes the new head; a shift moves each entry one slot toward the tail.
  assign ram_we    = cmd.push || cmd.shift_wr;
  assign ram_waddr = cmd.push ? fill[AW-1:0] : rd_addr - AW'(1);
  assign ram_wdata = cmd.push ? val_r : rd_data;

  vls_ram #(
    .WIDTH(32),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(iss_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      iss_done  <= 1'b1;
      rd_vld    <= 1'b0;
      s1_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        fill <= fill + CW'(1);
      end else if (cmd.dec) begin
        fill <= fill - CW'(1);
      end
      if (cmd.start_down || cmd.start_up || cmd.start_shift) begin
        iss_done <= 1'b0;
      end else if (cmd.issue) begin
        iss_done <= cmd.up ? (iss_addr == top_addr) : (iss_addr == '0);
      end
      rd_vld <= cmd.issue;
      s1_vld <= rd_vld;
      if (cmd.post) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= command;
      val_r <= value;
      acc   <= '0;
    end else if (s1_vld) begin
      acc <= acc_sum;
    end
    if (cmd.start_down) begin
      iss_addr <= top_addr;
    end else if (cmd.start_up) begin
      iss_addr <= '0;
    end else if (cmd.start_shift) begin
      iss_addr <= rd_addr + AW'(1);
    end else if (cmd.issue) begin
      iss_addr <= cmd.up ? iss_addr + AW'(1) : iss_addr - AW'(1);
    end
    rd_addr <= iss_addr;
    s1_add  <= ends_in_seven(rd_data) ? rd_data : 32'd0;
    s1_last <= (rd_addr == top_addr);
    if (cmd.res_we) begin
      res_status <= cmd.res_status;
      res_pos    <= cmd.res_pos ? pos_ext[6:0] : 7'd0;
      res_total  <= cmd.res_sum ? acc_sum : 38'd0;
    end
    if (cmd.post) begin
      status      <= res_status;
      position    <= res_pos;
      total       <= res_total;
      entry_count <= fill_ext[6:0];
    end
  end

  always_comb begin
    stat.cmd          = cmd_r;
    stat.empty        = (fill == '0);
    stat.full         = (fill == CW'(MAX_ENTRIES));
    stat.iss_done     = iss_done;
    stat.rd_vld       = rd_vld;
    stat.match        = (rd_data == val_r);
    stat.rd_at_top    = (rd_addr == top_addr);
    stat.rd_at_bottom = (rd_addr == '0);
    stat.s1_vld       = s1_vld;
    stat.s1_last      = s1_last;
    stat.out_free     = !out_valid || !out_stall;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(MAX_ENTRIES))
    else $error("fill count above capacity");

  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> (rd_addr != '0) && !cmd.push)
    else $error("shift write below slot zero or alongside a push");

  a_kill_inflight: assert property (@(posedge clk) disable iff (rst)
    cmd.start_shift |=> !rd_vld)
    else $error("stale scan read reached the shift");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> fill == $past(fill) + CW'(1))
    else $error("push did not grow the list by one");

endmodule

// File: rtl/vls_ctrl.sv
// Controller: sequences push, scan, shift and result posting for one beat at a time.
module vls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  vls_pkg::dp_stat_t stat,
  output vls_pkg::dp_cmd_t  cmd
);
  import vls_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       hit;

  assign in_stall = (state != S_IDLE);
  assign hit      = stat.rd_vld && stat.match;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.up     = (state == S_SHIFT) || (stat.cmd == CMD_SUM);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (stat.cmd)
          CMD_PUSH: begin
            cmd.res_we = 1'b1;
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.push       = 1'b1;
              cmd.res_status = ST_OK;
            end
          end
          CMD_DELETE: begin
            if (stat.empty) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ST_NOT_FOUND;
            end else begin
              cmd.start_down = 1'b1;
              state_next     = S_SCAN;
            end
          end
          CMD_SEARCH: begin
            if (stat.empty) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.start_down = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            if (stat.empty) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.start_up = 1'b1;
              state_next   = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (stat.cmd == CMD_SUM) begin
          cmd.issue = !stat.iss_done;
          if (stat.s1_vld && stat.s1_last) begin
            cmd.res_we     = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_sum    = 1'b1;
            state_next     = S_DONE;
          end
        end else begin
          // stop issuing on the first match, counted from the head
          cmd.issue = !stat.iss_done && !hit;
          if (hit) begin
            if (stat.cmd == CMD_SEARCH) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ST_OK;
              cmd.res_pos    = 1'b1;
              state_next     = S_DONE;
            end else if (stat.rd_at_top) begin
              cmd.dec        = 1'b1;
              cmd.res_we     = 1'b1;
              cmd.res_status = ST_OK;
              state_next     = S_DONE;
            end else begin
              cmd.start_shift = 1'b1;
              state_next      = S_SHIFT;
            end
          end else if (stat.rd_vld && stat.rd_at_bottom) begin
            cmd.res_we     = 1'b1;
            cmd.res_status = ST_NOT_FOUND;
            state_next     = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        cmd.issue    = !stat.iss_done;
        cmd.shift_wr = stat.rd_vld;
        if (stat.rd_vld && stat.rd_at_top) begin
          cmd.dec        = 1'b1;
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for value_list_store_unit: directed and random list commands.
module testbench;
  import vls_pkg::*;

  localparam int LIST_DEPTH  = 64;
  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 160;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  position;
    logic [37:0] total;
    logic [6:0]  entry_count;
  } list_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         command;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic [6:0]         position;
  logic [37:0]        total;
  logic [6:0]         entry_count;

  // shadow copy of the list: slot 0 is the oldest entry, slot list_len-1 the head
  logic [31:0]  list_mem [LIST_DEPTH];
  int           list_len = 0;
  list_result_t pending_results[$];
  int           error_count = 0;
  int           stuck_cycles = 0;
  bit           quiet = 1'b0;
  bit           hold_req = 1'b0;

  value_list_store_unit #(.MAX_ENTRIES(LIST_DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .position   (position),
    .total      (total),
    .entry_count(entry_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic list_result_t apply_list_op(logic [1:0] cmd, logic [31:0] v);
    list_result_t res;
    int           hit;
    res = '0;
    hit = -1;
    case (cmd)
      CMD_PUSH: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_mem[list_len] = v;
          list_len++;
        end
      end
      CMD_DELETE: begin
        for (int i = list_len - 1; i >= 0 && hit < 0; i--) begin
          if (list_mem[i] == v) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int i = hit; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      CMD_SEARCH: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOT_FOUND;
          for (int i = 0; i < list_len && res.status != ST_OK; i++) begin
            if (list_mem[list_len - 1 - i] == v) begin
              res.status   = ST_OK;
              res.position = 7'(i + 1);
            end
          end
        end
      end
      default: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < list_len; i++) begin
            if (!list_mem[i][31] && (list_mem[i] % 10 == 7)) res.total += 38'(list_mem[i]);
          end
        end
      end
    endcase
    res.entry_count = 7'(list_len);
    return res;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 && list_len > 0) return list_mem[$urandom_range(0, list_len - 1)];
    if (r < 60) return 32'($urandom_range(0, 40)) - 32'd20;
    if (r < 75) return 32'd10 * 32'($urandom_range(0, 214748364)) + 32'd7;
    if (r < 85) begin
      case ($urandom_range(0, 4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'hFFFF_FFFF;
        3: return 32'h0000_0000;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [1:0] pick_command(int push_pct);
    if ($urandom_range(0, 99) < push_pct) return CMD_PUSH;
    case ($urandom_range(0, 4))
      0, 1: return CMD_DELETE;
      2, 3: return CMD_SEARCH;
      default: return CMD_SUM;
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    // keep the log short when the block is badly broken
    if (error_count < 40) $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // entered and left at a falling edge
  task automatic send_beat(logic [1:0] cmd, logic [31:0] v);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_list_op(cmd, v));
    @(negedge clk);
  endtask

  task automatic test_empty_list();
    send_beat(CMD_DELETE, 32'd5);
    send_beat(CMD_SEARCH, 32'd0);
    send_beat(CMD_SUM, 32'd0);
    send_beat(CMD_SEARCH, 32'hFFFF_FFFF);
  endtask

  task automatic test_basic_ops();
    send_beat(CMD_PUSH, 32'd7);
    send_beat(CMD_PUSH, -32'sd7);
    send_beat(CMD_PUSH, 32'd17);
    send_beat(CMD_PUSH, 32'h7FFF_FFFF);
    send_beat(CMD_PUSH, 32'h8000_0000);
    send_beat(CMD_PUSH, 32'd0);
    send_beat(CMD_PUSH, 32'd7);
    send_beat(CMD_SEARCH, 32'd7);
    send_beat(CMD_SEARCH, 32'd17);
    send_beat(CMD_SEARCH, 32'd99);
    send_beat(CMD_SUM, 32'd0);
    send_beat(CMD_DELETE, 32'd7);
    send_beat(CMD_SEARCH, 32'd7);
    send_beat(CMD_DELETE, 32'd17);
    send_beat(CMD_DELETE, 32'h8000_0000);
    send_beat(CMD_DELETE, 32'd12345);
    send_beat(CMD_SUM, 32'd0);
    send_beat(CMD_DELETE, 32'd7);
    send_beat(CMD_SEARCH, -32'sd7);
  endtask

  task automatic test_backpressure();
    hold_req = ~hold_req;
    for (int i = 0; i < 20; i++) send_beat(pick_command(50), pick_value());
  endtask

  task automatic test_full_list();
    while (list_len > 0) send_beat(CMD_DELETE, list_mem[list_len - 1]);
    send_beat(CMD_PUSH, 32'h8000_0000);
    while (list_len < LIST_DEPTH) send_beat(CMD_PUSH, 32'h7FFF_FFFF);
    send_beat(CMD_PUSH, 32'd1);
    send_beat(CMD_SUM, 32'd0);
    send_beat(CMD_SEARCH, 32'h8000_0000);
    // oldest entry: longest scan plus full shift
    send_beat(CMD_DELETE, 32'h8000_0000);
    send_beat(CMD_PUSH, 32'h7FFF_FFFF);
    send_beat(CMD_SUM, 32'd0);
    send_beat(CMD_SEARCH, 32'h7FFF_FFFF);
  endtask

  task automatic test_random(int n);
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < n; i++) begin
      // phases lean toward filling or draining so both ends of the list get reached
      if (i % 60 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 15;
          1: push_pct = 40;
          2: push_pct = 60;
          default: push_pct = 85;
        endcase
      end
      send_beat(pick_command(push_pct), pick_value());
    end
  endtask

  task automatic test_steady_stream();
    quiet = 1'b1;
    test_random(200);
    quiet = 1'b0;
  endtask

  // receiver: random stall, plus a long hold-off on request
  initial begin
    int hold_left;
    bit last_req;
    hold_left = 0;
    last_req  = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != last_req) begin
        last_req  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 12);
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result beat with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (position !== want.position)
          flag_mismatch($sformatf("position %0d, want %0d", position, want.position));
        if (total !== want.total)
          flag_mismatch($sformatf("total %0d, want %0d", total, want.total));
        if (entry_count !== want.entry_count)
          flag_mismatch($sformatf("entry_count %0d, want %0d", entry_count, want.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TIMEOUT: no beat moved for %0d cycles", STUCK_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    command  = CMD_PUSH;
    value    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_list();
    test_basic_ops();
    test_backpressure();
    test_full_list();
    test_random(800);
    test_steady_stream();
    test_random(700);

    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
